// File: rtl/pf_pkg.sv
// Shared constants for the prime factoriser.
package pf_pkg;

    localparam int FIELD_W       = 16;
    localparam int MAX_RESULTS   = 16;
    localparam int CNT_W         = $clog2(MAX_RESULTS);
    localparam int FIRST_DIVISOR = 2;

    typedef logic [FIELD_W-1:0] field_t;

endpackage : pf_pkg

// File: rtl/prime_factorizer.sv
// Trial-division prime factoriser: sequencer around a shared serial divider.
//
// Takes one number per input beat and returns its prime factors smallest
// first, one per output beat, the final one flagged by last; 0 and 1 give a
// single beat with factor 0 and no_factors set. Only the low WIDTH bits of
// number are used (at most 16). Each trial divisor is one run of the
// bit-serial divider that all trials share, DW = min(WIDTH, 16) bits wide,
// and each factor found adds an emit state. A 16-bit input needs up to
// about 255 trials. in_ready is high only while no number is in work; the
// output register lets the next number enter while the last factor still
// waits to be taken.
module prime_factorizer #(
    parameter int WIDTH = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [pf_pkg::FIELD_W-1:0] number,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [pf_pkg::FIELD_W-1:0] factor,
    output logic                   last,
    output logic                   no_factors
);

    import pf_pkg::*;

    localparam int DW = (WIDTH < FIELD_W) ? WIDTH : FIELD_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_EMIT
    } state_t;

    state_t         state_reg;
    logic           div_start_reg;
    logic [DW-1:0]  x_reg;
    logic [DW-1:0]  d_reg;
    logic [DW:0]    sq_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic [DW-1:0]  pend_factor_reg;
    logic           pend_last_reg;
    logic           pend_none_reg;

    logic           out_valid_reg;
    field_t         factor_reg;
    logic           last_reg;
    logic           none_reg;

    logic           div_done;
    logic [DW-1:0]  div_quo;
    logic [DW-1:0]  div_rem;
    logic [DW-1:0]  x_in;
    logic           slot_free;

    assign x_in      = number[DW-1:0];
    assign slot_free = !out_valid_reg || out_ready;

    pf_divider #(
        .W (DW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start_reg),
        .dividend  (x_reg),
        .divisor   (d_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            div_start_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            div_start_reg <= 1'b0;
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        x_reg   <= x_in;
                        d_reg   <= DW'(FIRST_DIVISOR);
                        sq_reg  <= (DW + 1)'(FIRST_DIVISOR * FIRST_DIVISOR);
                        cnt_reg <= '0;
                        if (x_in < DW'(FIRST_DIVISOR))
                        begin
                            pend_factor_reg <= '0;
                            pend_last_reg   <= 1'b1;
                            pend_none_reg   <= 1'b1;
                            state_reg       <= S_EMIT;
                        end
                        else
                        begin
                            state_reg <= S_CHECK;
                        end
                    end
                end

                S_CHECK:
                begin
                    if (sq_reg <= {1'b0, x_reg})
                    begin
                        div_start_reg <= 1'b1;
                        state_reg     <= S_DIV;
                    end
                    else
                    begin
                        // no divisor left: the cofactor is the largest prime
                        pend_factor_reg <= x_reg;
                        pend_last_reg   <= 1'b1;
                        pend_none_reg   <= 1'b0;
                        state_reg       <= S_EMIT;
                    end
                end

                S_DIV:
                begin
                    if (div_done)
                    begin
                        if (div_rem == '0)
                        begin
                            pend_none_reg <= 1'b0;
                            if (cnt_reg == CNT_W'(MAX_RESULTS - 1))
                            begin
                                pend_factor_reg <= x_reg;
                                pend_last_reg   <= 1'b1;
                            end
                            else
                            begin
                                pend_factor_reg <= d_reg;
                                pend_last_reg   <= 1'b0;
                                x_reg           <= div_quo;
                                cnt_reg         <= cnt_reg + CNT_W'(1);
                            end
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            // (d+1)^2 = d^2 + 2d + 1
                            d_reg     <= d_reg + DW'(1);
                            sq_reg    <= sq_reg + {d_reg, 1'b1};
                            state_reg <= S_CHECK;
                        end
                    end
                end

                S_EMIT:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg <= 1'b1;
                        factor_reg    <= FIELD_W'(pend_factor_reg);
                        last_reg      <= pend_last_reg;
                        none_reg      <= pend_none_reg;
                        state_reg     <= pend_last_reg ? S_IDLE : S_CHECK;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign factor     = factor_reg;
    assign last       = last_reg;
    assign no_factors = none_reg;

endmodule : prime_factorizer

// File: rtl/pf_divider.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module pf_divider #(
    parameter int W = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient,
    output logic [W-1:0] remainder
);

    localparam int CW = $clog2(W + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [W-1:0]  quo_reg;
    logic [W-1:0]  rem_reg;

    logic [W:0]    rem_sh;
    logic [W:0]    diff;
    logic          ge;

    assign rem_sh = {rem_reg, quo_reg[W-1]};
    assign diff   = rem_sh - {1'b0, divisor};
    assign ge     = (rem_sh >= {1'b0, divisor});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so W bits hold it
            rem_reg <= ge ? diff[W-1:0] : rem_sh[W-1:0];
            quo_reg <= {quo_reg[W-2:0], ge};
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule : pf_divider
